@@ rtl/msadpcm_pkg.sv @@
// Shared types, constants and the step adaptation table for the MS-ADPCM
// block decoder. Used by msadpcm_ctrl, msadpcm_dp and the top level.
`default_nettype none

package msadpcm_pkg;

  localparam int unsigned HDR_BYTES_PER_CH = 7;
  localparam int unsigned NUM_PRED         = 7;
  localparam logic [2:0]  MAX_PRED         = 3'd6;
  localparam logic [15:0] MIN_STEP         = 16'd16;
  localparam logic [15:0] MAX_STEP         = 16'h7fff;
  localparam logic signed [31:0] STEP_FLOOR = 32'sd4096;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_CHANNELS = 3'd0;
  localparam logic [1:0] NCH_STEREO       = 2'd2;

  localparam logic [31:0] COEF_RESET [NUM_PRED] = '{
    32'd256, 32'd4278190592, 32'd0, 32'd4194496,
    32'd240, 32'd4281336268, 32'd4279763336
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               channel;
    logic               last_of_item;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_EMIT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIST_NEW,
    OP_HIST_OLD,
    OP_STEP_CODE,
    OP_STEP_ADAPT
  } mul_op_t;

  typedef struct packed {
    logic       capture;
    logic       hdr_wr;
    mul_op_t    op;
    logic       nib;
    logic       emit_hdr;
    logic       emit_nib;
    logic [1:0] emit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_hdr;
    logic hdr_last;
    logic stereo;
    logic out_free;
  } dp_stat_t;

  function automatic logic [9:0] adapt_factor(input logic [3:0] code);
    logic [9:0] f;
    case (code)
      4'd4:    f = 10'd307;
      4'd5:    f = 10'd409;
      4'd6:    f = 10'd512;
      4'd7:    f = 10'd614;
      4'd8:    f = 10'd768;
      4'd9:    f = 10'd614;
      4'd10:   f = 10'd512;
      4'd11:   f = 10'd409;
      4'd12:   f = 10'd307;
      default: f = 10'd230;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ms_adpcm_block_decoder.sv @@
// MS-ADPCM block decoder, one compressed byte per input request. Header
// bytes pass through the idle and class states; the last header byte then
// emits 2 (mono) or 4 (stereo) samples, one per cycle unless the output
// stalls. A data byte passes the same states, then each nibble runs four
// steps through a single shared 16x16 multiplier (two history products,
// step times code, step adaptation) and hands its sample to the output
// register, waiting through output stalls. The output register lets a new
// byte be accepted while the last sample still waits. Configuration writes
// are always ready. Depends on msadpcm_pkg, msadpcm_ctrl and msadpcm_dp.
`default_nettype none

module ms_adpcm_block_decoder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire msadpcm_pkg::in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output msadpcm_pkg::out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata
);

  msadpcm_pkg::dp_cmd_t  cmd;
  msadpcm_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  msadpcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  msadpcm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/msadpcm_ctrl.sv @@
// Sequencer of the MS-ADPCM block decoder: input request handshake,
// header emission count and the four multiply steps per nibble.
// Depends on msadpcm_pkg.
`default_nettype none

module msadpcm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire msadpcm_pkg::dp_stat_t stat,
  output msadpcm_pkg::dp_cmd_t      cmd
);

  msadpcm_pkg::state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       nib_r, nib_nxt;
  logic [1:0] last_idx;

  assign last_idx = stat.stereo ? 2'd3 : 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msadpcm_pkg::ST_IDLE;
      cnt_r   <= 2'd0;
      nib_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nib_r   <= nib_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    nib_nxt   = nib_r;
    case (state_r)
      msadpcm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = msadpcm_pkg::ST_CLASS;
      end
      msadpcm_pkg::ST_CLASS: begin
        if (stat.is_hdr) begin
          cnt_nxt   = 2'd0;
          state_nxt = stat.hdr_last ? msadpcm_pkg::ST_EMIT : msadpcm_pkg::ST_IDLE;
        end else begin
          nib_nxt   = 1'b0;
          state_nxt = msadpcm_pkg::ST_MUL0;
        end
      end
      msadpcm_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          if (cnt_r == last_idx) state_nxt = msadpcm_pkg::ST_IDLE;
          else cnt_nxt = cnt_r + 2'd1;
        end
      end
      msadpcm_pkg::ST_MUL0: state_nxt = msadpcm_pkg::ST_MUL1;
      msadpcm_pkg::ST_MUL1: state_nxt = msadpcm_pkg::ST_MUL2;
      msadpcm_pkg::ST_MUL2: state_nxt = msadpcm_pkg::ST_MUL3;
      msadpcm_pkg::ST_MUL3: state_nxt = msadpcm_pkg::ST_OUT;
      msadpcm_pkg::ST_OUT: begin
        if (stat.out_free) begin
          if (nib_r) begin
            state_nxt = msadpcm_pkg::ST_IDLE;
          end else begin
            nib_nxt   = 1'b1;
            state_nxt = msadpcm_pkg::ST_MUL0;
          end
        end
      end
      default: state_nxt = msadpcm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.op       = msadpcm_pkg::OP_NONE;
    cmd.nib      = nib_r;
    cmd.emit_idx = cnt_r;
    in_stall     = 1'b1;
    case (state_r)
      msadpcm_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      msadpcm_pkg::ST_CLASS: cmd.hdr_wr   = stat.is_hdr;
      msadpcm_pkg::ST_EMIT:  cmd.emit_hdr = stat.out_free;
      msadpcm_pkg::ST_MUL0:  cmd.op       = msadpcm_pkg::OP_HIST_NEW;
      msadpcm_pkg::ST_MUL1:  cmd.op       = msadpcm_pkg::OP_HIST_OLD;
      msadpcm_pkg::ST_MUL2:  cmd.op       = msadpcm_pkg::OP_STEP_CODE;
      msadpcm_pkg::ST_MUL3:  cmd.op       = msadpcm_pkg::OP_STEP_ADAPT;
      msadpcm_pkg::ST_OUT:   cmd.emit_nib = stat.out_free;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_hdr || cmd.emit_nib) |-> stat.out_free)
    else $error("result loaded while output register is occupied");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == msadpcm_pkg::ST_MUL3 |=> state_r == msadpcm_pkg::ST_OUT)
    else $error("nibble result not presented after last multiply step");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == msadpcm_pkg::ST_EMIT |-> cnt_r <= last_idx)
    else $error("header emit count past channel range");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(nib_r) |-> $past(state_r) == msadpcm_pkg::ST_OUT)
    else $error("second nibble started before first result was handed off");

endmodule

`default_nettype wire

@@ rtl/msadpcm_dp.sv @@
// Datapath of the MS-ADPCM block decoder: configuration registers, channel
// state, shared 16x16 multiplier, prediction clamp and output register.
// Depends on msadpcm_pkg; driven by msadpcm_ctrl.
`default_nettype none

module msadpcm_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire msadpcm_pkg::in_t     in_data,
  input  wire logic                 cfg_valid,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  input  wire msadpcm_pkg::dp_cmd_t cmd,
  output msadpcm_pkg::dp_stat_t     stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output msadpcm_pkg::out_t         out_data
);

  logic [1:0]  nch_r;
  logic [31:0] coef_r [msadpcm_pkg::NUM_PRED];

  logic [3:0]  pos_r;
  logic [2:0]  pidx_r  [2];
  logic [15:0] step_r  [2];
  logic [15:0] newer_r [2];
  logic [15:0] older_r [2];

  logic [7:0]  byte_r;
  logic        start_r;
  logic signed [32:0] acc_r;
  logic signed [20:0] stsc_r;
  logic [15:0] smp_r;

  logic              out_valid_r;
  msadpcm_pkg::out_t out_data_r;

  // control decode
  logic        stereo;
  logic [3:0]  hlen, nchv, pos_eff, hr;
  logic [1:0]  grp;
  logic        hch, hhi;
  logic [2:0]  psat;
  logic        ch;
  logic [3:0]  code;
  logic [31:0] coef;
  logic        out_free;

  // arithmetic
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] mul_p;
  logic signed [24:0] pred_base;
  logic signed [25:0] pred_sum;
  logic [15:0]        pred_sat, step_new;

  // header emission
  logic        e_new, e_ch, e_last;
  logic [15:0] e_smp;

  always_comb begin
    stereo  = (nch_r == msadpcm_pkg::NCH_STEREO);
    hlen    = stereo ? 4'(2 * msadpcm_pkg::HDR_BYTES_PER_CH)
                     : 4'(msadpcm_pkg::HDR_BYTES_PER_CH);
    nchv    = stereo ? 4'd2 : 4'd1;
    pos_eff = start_r ? 4'd0 : pos_r;
    hr      = pos_eff - nchv;
    grp     = stereo ? hr[3:2] : hr[2:1];
    hch     = stereo & hr[1];
    hhi     = hr[0];
    psat    = (byte_r > {5'd0, msadpcm_pkg::MAX_PRED}) ? msadpcm_pkg::MAX_PRED
                                                       : byte_r[2:0];
    ch      = cmd.nib & stereo;
    code    = cmd.nib ? byte_r[3:0] : byte_r[7:4];
    coef    = coef_r[pidx_r[ch]];
    out_free = !out_valid_r || !out_stall;

    stat.is_hdr   = pos_eff < hlen;
    stat.hdr_last = ({1'b0, pos_eff} + 5'd1) == {1'b0, hlen};
    stat.stereo   = stereo;
    stat.out_free = out_free;
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      msadpcm_pkg::OP_HIST_NEW: begin
        mul_a = newer_r[ch];
        mul_b = coef[15:0];
      end
      msadpcm_pkg::OP_HIST_OLD: begin
        mul_a = older_r[ch];
        mul_b = coef[31:16];
      end
      msadpcm_pkg::OP_STEP_CODE: begin
        mul_a = step_r[ch];
        mul_b = {{12{code[3]}}, code};
      end
      msadpcm_pkg::OP_STEP_ADAPT: begin
        mul_a = step_r[ch];
        mul_b = {6'd0, msadpcm_pkg::adapt_factor(code)};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    // floor division by 256 of the history sum
    pred_base = acc_r[32:8];
    pred_sum  = {pred_base[24], pred_base} + {{5{stsc_r[20]}}, stsc_r};
    if (pred_sum > 26'sd32767)       pred_sat = 16'h7fff;
    else if (pred_sum < -26'sd32768) pred_sat = 16'h8000;
    else                             pred_sat = pred_sum[15:0];

    if (mul_p < msadpcm_pkg::STEP_FLOOR) step_new = msadpcm_pkg::MIN_STEP;
    else if (|mul_p[30:23])              step_new = msadpcm_pkg::MAX_STEP;
    else                                 step_new = mul_p[23:8];
  end

  always_comb begin
    e_new  = stereo ? cmd.emit_idx[1] : cmd.emit_idx[0];
    e_ch   = stereo & cmd.emit_idx[0];
    e_smp  = e_new ? newer_r[e_ch] : older_r[e_ch];
    e_last = stereo ? (cmd.emit_idx == 2'd3) : (cmd.emit_idx == 2'd1);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nch_r <= 2'd1;
      for (int i = 0; i < msadpcm_pkg::NUM_PRED; i++) begin
        coef_r[i] <= msadpcm_pkg::COEF_RESET[i];
      end
    end else if (cfg_valid) begin
      if (cfg_index == msadpcm_pkg::CFG_NUM_CHANNELS) nch_r <= cfg_wdata[1:0];
      else coef_r[3'(cfg_index - 3'd1)] <= cfg_wdata;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      for (int i = 0; i < 2; i++) begin
        pidx_r[i]  <= 3'd0;
        step_r[i]  <= 16'd0;
        newer_r[i] <= 16'd0;
        older_r[i] <= 16'd0;
      end
    end else begin
      if (cmd.hdr_wr) begin
        pos_r <= pos_eff + 4'd1;
        if (pos_eff < nchv) begin
          pidx_r[pos_eff[0]] <= psat;
        end else begin
          case (grp)
            2'd0: begin
              if (hhi) step_r[hch][15:8] <= byte_r;
              else     step_r[hch][7:0]  <= byte_r;
            end
            2'd1: begin
              if (hhi) newer_r[hch][15:8] <= byte_r;
              else     newer_r[hch][7:0]  <= byte_r;
            end
            default: begin
              if (hhi) older_r[hch][15:8] <= byte_r;
              else     older_r[hch][7:0]  <= byte_r;
            end
          endcase
        end
      end
      if (cmd.op == msadpcm_pkg::OP_STEP_ADAPT) begin
        step_r[ch]  <= step_new;
        older_r[ch] <= newer_r[ch];
        newer_r[ch] <= pred_sat;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r  <= in_data.data_byte;
      start_r <= in_data.block_start;
    end
    case (cmd.op)
      msadpcm_pkg::OP_HIST_NEW:   acc_r  <= {mul_p[31], mul_p};
      msadpcm_pkg::OP_HIST_OLD:   acc_r  <= acc_r + {mul_p[31], mul_p};
      msadpcm_pkg::OP_STEP_CODE:  stsc_r <= mul_p[20:0];
      msadpcm_pkg::OP_STEP_ADAPT: smp_r  <= pred_sat;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_hdr || cmd.emit_nib) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hdr) begin
      out_data_r.pcm_sample   <= e_smp;
      out_data_r.channel      <= e_ch;
      out_data_r.last_of_item <= e_last;
    end else if (cmd.emit_nib) begin
      out_data_r.pcm_sample   <= smp_r;
      out_data_r.channel      <= ch;
      out_data_r.last_of_item <= cmd.nib;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ dv/tb_ms_adpcm_block_decoder.sv @@
// Self-checking testbench for ms_adpcm_block_decoder: streams MS-ADPCM block bytes
// in random bursts and compares every decoded sample with a built-in predictor.
// Depends on msadpcm_pkg and the decoder RTL.
module tb_ms_adpcm_block_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_COEF_BASE = 3'd1;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 150;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES = 6;
  // header word groups, in stream order
  localparam int HW_STEP = 0;
  localparam int HW_NEWER = 1;
  localparam int HW_OLDER = 2;
  localparam int ADAPT_GAIN [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                                     768, 614, 512, 409, 307, 230, 230, 230};

  typedef enum int {MIX_RESET, MIX_RANDOM, MIX_EDGE, MIX_FIXED} coef_mix_t;

  class pcm_scoreboard;
    logic [1:0]  chan_reg;
    logic [31:0] coef[msadpcm_pkg::NUM_PRED];
    logic [3:0]  hdr_pos;
    logic [2:0]  pred_sel[2];
    logic [15:0] hdr_word[3][2];
    msadpcm_pkg::out_t pcm_expected[$];
    int          mismatches;
    int          checked;

    function new();
      chan_reg = 2'd1;
      foreach (coef[k]) coef[k] = msadpcm_pkg::COEF_RESET[k];
      hdr_pos = '0;
      pred_sel = '{default: '0};
      hdr_word = '{default: '0};
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      if (idx == msadpcm_pkg::CFG_NUM_CHANNELS) chan_reg = val[1:0];
      else coef[idx - CFG_COEF_BASE] = val;
    endfunction

    function int channels();
      return (chan_reg == msadpcm_pkg::NCH_STEREO) ? 2 : 1;
    endfunction

    function void expect_sample(logic [15:0] s, int ch, bit last);
      msadpcm_pkg::out_t e;
      e.pcm_sample = s;
      e.channel = ch[0];
      e.last_of_item = last;
      pcm_expected.push_back(e);
    endfunction

    // One nibble: predict from history, correct by step*code, adapt the step.
    function logic [15:0] predict_code(int ch, logic [3:0] code);
      int p, prod, ns;
      longint c0, c1, s1, s2, st, sc, acc;
      p = (pred_sel[ch] > msadpcm_pkg::MAX_PRED) ? int'(msadpcm_pkg::MAX_PRED)
                                                 : int'(pred_sel[ch]);
      c0 = longint'($signed(coef[p][15:0]));
      c1 = longint'($signed(coef[p][31:16]));
      s1 = longint'($signed(hdr_word[HW_NEWER][ch]));
      s2 = longint'($signed(hdr_word[HW_OLDER][ch]));
      st = longint'($signed(hdr_word[HW_STEP][ch]));
      sc = longint'($signed(code));
      acc = (s1 * c0 + s2 * c1) >>> 8;
      acc = acc + st * sc;
      if (acc < -32768) acc = -32768;
      if (acc > 32767) acc = 32767;
      prod = int'(st) * ADAPT_GAIN[code];
      if (prod < msadpcm_pkg::STEP_FLOOR) begin
        ns = int'(msadpcm_pkg::MIN_STEP);
      end else begin
        ns = prod >>> 8;
        if (ns > int'(msadpcm_pkg::MAX_STEP)) ns = int'(msadpcm_pkg::MAX_STEP);
      end
      hdr_word[HW_STEP][ch] = ns[15:0];
      hdr_word[HW_OLDER][ch] = hdr_word[HW_NEWER][ch];
      hdr_word[HW_NEWER][ch] = acc[15:0];
      return acc[15:0];
    endfunction

    function void take_byte(msadpcm_pkg::in_t it);
      int nch, hlen, pos, r, grp, slot, ch;
      logic [15:0] first, second;
      nch = channels();
      hlen = int'(msadpcm_pkg::HDR_BYTES_PER_CH) * nch;
      if (it.block_start) hdr_pos = '0;
      if (hdr_pos < hlen) begin
        pos = int'(hdr_pos);
        if (pos < nch) begin
          pred_sel[pos] = (it.data_byte > msadpcm_pkg::MAX_PRED) ? msadpcm_pkg::MAX_PRED
                                                                 : it.data_byte[2:0];
        end else begin
          r = pos - nch;
          grp = r / (2 * nch);
          slot = r % (2 * nch);
          ch = slot >> 1;
          if (slot[0]) hdr_word[grp][ch][15:8] = it.data_byte;
          else hdr_word[grp][ch][7:0] = it.data_byte;
        end
        hdr_pos = 4'(pos + 1);
        if (pos + 1 == hlen) begin
          for (int c = 0; c < nch; c++) expect_sample(hdr_word[HW_OLDER][c], c, 1'b0);
          for (int c = 0; c < nch; c++)
            expect_sample(hdr_word[HW_NEWER][c], c, c == nch - 1);
        end
      end else begin
        first = predict_code(0, it.data_byte[7:4]);
        second = predict_code(nch - 1, it.data_byte[3:0]);
        expect_sample(first, 0, 1'b0);
        expect_sample(second, nch - 1, 1'b1);
      end
    endfunction

    function void check_sample(msadpcm_pkg::out_t got);
      msadpcm_pkg::out_t e;
      checked++;
      if (pcm_expected.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected sample: pcm %0d ch %0d last %0d",
                   got.pcm_sample, got.channel, got.last_of_item);
        mismatches++;
      end else begin
        e = pcm_expected.pop_front();
        if (got.pcm_sample !== e.pcm_sample || got.channel !== e.channel ||
            got.last_of_item !== e.last_of_item) begin
          if (mismatches < 10)
            $display("sample mismatch: got pcm %0d ch %0d last %0d, expected pcm %0d ch %0d last %0d",
                     got.pcm_sample, got.channel, got.last_of_item,
                     e.pcm_sample, e.channel, e.last_of_item);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return pcm_expected.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  msadpcm_pkg::in_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  msadpcm_pkg::out_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  pcm_scoreboard sb = new();
  int burst_left = 0;
  int bytes_sent = 0;

  ms_adpcm_block_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL ms_adpcm_block_decoder");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    msadpcm_pkg::in_t it;
    int gap;
    it.data_byte = b;
    it.block_start = start;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.take_byte(it);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected sample is out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] edge_pair();
    case ($urandom_range(0, 5))
      0: return 32'h7fff7fff;
      1: return 32'h80008000;
      2: return 32'hffffffff;
      3: return 32'h00000000;
      4: return {16'($urandom_range(0, 65535)), 16'h7fff};
      default: return $urandom;
    endcase
  endfunction

  task automatic program_regs(input logic [1:0] chans, input coef_mix_t mix);
    logic [31:0] fixed_set [msadpcm_pkg::NUM_PRED];
    logic [31:0] val;
    fixed_set = '{32'h7fff7fff, 32'h80008000, 32'hffffffff, 32'h00000000,
                  32'h7fff8000, 32'h80007fff, 32'h00010001};
    write_reg(msadpcm_pkg::CFG_NUM_CHANNELS, {30'd0, chans});
    for (int k = 0; k < msadpcm_pkg::NUM_PRED; k++) begin
      case (mix)
        MIX_RESET:  val = msadpcm_pkg::COEF_RESET[k];
        MIX_RANDOM: val = $urandom;
        MIX_EDGE:   val = edge_pair();
        default:    val = fixed_set[k];
      endcase
      write_reg(CFG_COEF_BASE + k[2:0], val);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_pred_byte();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(7, 255))
                                       : 8'($urandom_range(0, 6));
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 16'h7f00 | 16'($urandom_range(0, 255));
      1: return 16'($urandom_range(0, 65535));
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(16, 3000));
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] edges [4];
    edges = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom_range(0, 65535));
      2: return edges[$urandom_range(0, 3)];
      default: return 16'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  // Header with random content; count below the full length cuts it short.
  task automatic send_header(input int nch, input int count);
    logic [7:0] hb[$];
    logic [15:0] w;
    for (int c = 0; c < nch; c++) hb.push_back(pick_pred_byte());
    for (int g = 0; g < 3; g++) begin
      for (int c = 0; c < nch; c++) begin
        w = (g == HW_STEP) ? pick_step() : pick_sample();
        hb.push_back(w[7:0]);
        hb.push_back(w[15:8]);
      end
    end
    for (int i = 0; i < count; i++) send_byte(hb[i], i == 0);
  endtask

  // Receiver: random stall pattern that changes over time, plus one long hold-off.
  initial begin
    int mode;
    int left;
    bit held;
    mode = 0;
    left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_sample(out_data);
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    logic [1:0] phase_chans [NUM_PHASES];
    coef_mix_t phase_mix [NUM_PHASES];
    int nch, hlen, start_items, pick;
    phase_chans = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
    phase_mix = '{MIX_RANDOM, MIX_RESET, MIX_EDGE, MIX_RANDOM, MIX_RESET, MIX_EDGE};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Mono header without any block start, then two data bytes; index saturates, step is negative.
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    settle();
    program_regs(msadpcm_pkg::NCH_STEREO, MIX_FIXED);

    // Stereo block with extreme history; step 32767 grows into saturation, step 0 to minimum.
    send_byte(8'h07, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h8f, 1'b0);
    settle();
    // Switch to mono mid-block: position is past the shorter header, so data follows.
    program_regs(2'd3, MIX_FIXED);
    send_byte(8'h08, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      program_regs(phase_chans[ph], phase_mix[ph]);
      nch = sb.channels();
      hlen = int'(msadpcm_pkg::HDR_BYTES_PER_CH) * nch;
      start_items = bytes_sent;
      // continue whatever block the previous setting left open
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      while (bytes_sent - start_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          send_header(nch, hlen);
          repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick == 7) begin
          send_header(nch, $urandom_range(1, hlen - 1));
        end else begin
          repeat ($urandom_range(1, 8))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
      // leave a header partly taken for the next setting
      if ($urandom_range(0, 1) == 0)
        send_header(nch, $urandom_range(1, hlen - 1));
    end

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS ms_adpcm_block_decoder");
    end else begin
      $display("FAIL ms_adpcm_block_decoder");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/msadpcm_pkg.sv
rtl/msadpcm_ctrl.sv
rtl/msadpcm_dp.sv
rtl/ms_adpcm_block_decoder.sv
dv/tb_ms_adpcm_block_decoder.sv
